// File: rtl/peu_pkg.sv
// Shared types, register codes and helpers for the particle Euler update block.
package peu_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned FRAC_W      = 17;

   localparam logic [CSR_INDEX_W-1:0] REG_GRAVITY_X    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_GRAVITY_Y    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_GRAVITY_Z    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_MASS         = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SIZE_RANGE   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_START_COLOR  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_END_COLOR    = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_INV_LIFETIME = 3'd7;

   localparam logic [31:0] MASS_RESET         = 32'h0001_0000;
   localparam logic [31:0] SIZE_RANGE_RESET   = 32'h0000_0000;
   localparam logic [23:0] START_COLOR_RESET  = 24'hFF_FFFF;
   localparam logic [23:0] END_COLOR_RESET    = 24'h00_0000;
   localparam logic [31:0] INV_LIFETIME_RESET = 32'h0001_0000;

   localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h1_0000;

   localparam logic signed [49:0] SAT_MAX = 50'sd2147483647;
   localparam logic signed [49:0] SAT_MIN = -50'sd2147483648;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [31:0] life_left;
      logic [15:0]        time_step;
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic signed [31:0] force_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] new_pos_x;
      logic signed [31:0] new_pos_y;
      logic signed [31:0] new_pos_z;
      logic signed [31:0] new_vel_x;
      logic signed [31:0] new_vel_y;
      logic signed [31:0] new_vel_z;
      logic signed [31:0] new_life_left;
      logic [15:0]        particle_size;
      logic [23:0]        particle_color;
      logic               expired;
   } rsp_payload_type;

   // Clamps a wide signed sum to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
      logic signed [31:0] res;
      if (x > SAT_MAX) begin
         res = 32'sh7FFF_FFFF;
      end else if (x < SAT_MIN) begin
         res = 32'sh8000_0000;
      end else begin
         res = x[31:0];
      end
      return res;
   endfunction

endpackage

// File: rtl/peu_stream_if.sv
// Valid/ready stream channel that carries one item per handshake.
interface peu_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/particle_euler_update.sv
// Four-stage pipeline that applies one explicit Euler step to a Q16.16 particle.
//
// The block accepts one particle per clock while the pipeline does not stall. The four
// register stages are: the products of velocity, force, gravity and life with the time
// step or the inverse lifetime; the force-times-mass product with the position update and
// the life fraction; the velocity sum and the size and color interpolation products; and
// the output register. A stage advances whenever it is empty or the stage after it
// advances, so req_if.ready follows rsp_if.ready through any empty stages. Configuration
// registers are read live by each stage and must only be written while the pipeline is
// empty.
module particle_euler_update (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [peu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [peu_pkg::CSR_DATA_W-1:0]  csr_wdata,
   peu_stream_if.sink                    req_if,
   peu_stream_if.source                  rsp_if
);
   import peu_pkg::*;

   logic signed [31:0] gravity_ff [3];
   logic [31:0]        mass_ff;
   logic [31:0]        size_range_ff;
   logic [23:0]        start_color_ff;
   logic [23:0]        end_color_ff;
   logic [31:0]        inv_life_ff;

   logic adv1, adv2, adv3, adv_out;

   // Stage 1
   logic               s1_v_ff;
   logic signed [31:0] s1_pos_in [3], s1_pos_ff [3];
   logic signed [31:0] s1_vel_in [3], s1_vel_ff [3];
   logic signed [31:0] s1_vdt_in [3], s1_vdt_ff [3];
   logic signed [31:0] s1_fdt_in [3], s1_fdt_ff [3];
   logic signed [31:0] s1_gdt_in [3], s1_gdt_ff [3];
   logic signed [47:0] s1_r_in, s1_r_ff;
   logic signed [31:0] s1_nlife_in, s1_nlife_ff;
   logic               s1_exp_in, s1_exp_ff;
   logic signed [31:0] frc_arr [3];
   logic signed [48:0] vprod [3], fprod [3], gprod [3];
   logic signed [64:0] lprod;
   logic signed [16:0] dt_s;
   logic signed [32:0] ldiff;

   // Stage 2
   logic               s2_v_ff;
   logic signed [31:0] s2_np_in [3], s2_np_ff [3];
   logic signed [32:0] s2_vg_in [3], s2_vg_ff [3];
   logic signed [47:0] s2_fm_in [3], s2_fm_ff [3];
   logic [FRAC_W-1:0]  s2_frac_in, s2_frac_ff;
   logic signed [31:0] s2_nlife_ff;
   logic               s2_exp_ff;
   logic signed [32:0] psum [3];
   logic signed [64:0] mprod [3];

   // Stage 3
   logic               s3_v_ff;
   logic signed [31:0] s3_nv_in [3], s3_nv_ff [3];
   logic signed [18:0] s3_off_in [4], s3_off_ff [4];
   logic signed [31:0] s3_np_ff [3];
   logic signed [31:0] s3_nlife_ff;
   logic               s3_exp_ff;
   logic [15:0]        lerp_a [4], lerp_b [4];
   logic signed [16:0] lerp_d [4];
   logic signed [34:0] lerp_p [4];

   // Output stage
   logic               out_v_ff;
   rsp_payload_type    out_in, out_ff;
   logic [18:0]        lerp_sum [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff[0]  <= '0;
         gravity_ff[1]  <= '0;
         gravity_ff[2]  <= '0;
         mass_ff        <= MASS_RESET;
         size_range_ff  <= SIZE_RANGE_RESET;
         start_color_ff <= START_COLOR_RESET;
         end_color_ff   <= END_COLOR_RESET;
         inv_life_ff    <= INV_LIFETIME_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_GRAVITY_X:    gravity_ff[0]  <= csr_wdata;
            REG_GRAVITY_Y:    gravity_ff[1]  <= csr_wdata;
            REG_GRAVITY_Z:    gravity_ff[2]  <= csr_wdata;
            REG_MASS:         mass_ff        <= csr_wdata;
            REG_SIZE_RANGE:   size_range_ff  <= csr_wdata;
            REG_START_COLOR:  start_color_ff <= csr_wdata[23:0];
            REG_END_COLOR:    end_color_ff   <= csr_wdata[23:0];
            REG_INV_LIFETIME: inv_life_ff    <= csr_wdata;
         endcase
      end
   end

   assign adv_out = !out_v_ff || rsp_if.ready;
   assign adv3    = !s3_v_ff || adv_out;
   assign adv2    = !s2_v_ff || adv3;
   assign adv1    = !s1_v_ff || adv2;

   assign req_if.ready  = adv1;
   assign rsp_if.valid  = out_v_ff;
   assign rsp_if.payload = out_ff;

   // Stage 1: products with the time step and the inverse lifetime, and the new remaining life.
   always_comb begin
      s1_pos_in[0] = req_if.payload.pos_x;
      s1_pos_in[1] = req_if.payload.pos_y;
      s1_pos_in[2] = req_if.payload.pos_z;
      s1_vel_in[0] = req_if.payload.vel_x;
      s1_vel_in[1] = req_if.payload.vel_y;
      s1_vel_in[2] = req_if.payload.vel_z;
      frc_arr[0]   = req_if.payload.force_x;
      frc_arr[1]   = req_if.payload.force_y;
      frc_arr[2]   = req_if.payload.force_z;
      dt_s         = $signed({1'b0, req_if.payload.time_step});
      for (int a = 0; a < 3; a++) begin
         vprod[a]     = s1_vel_in[a] * dt_s;
         fprod[a]     = frc_arr[a] * dt_s;
         gprod[a]     = gravity_ff[a] * dt_s;
         s1_vdt_in[a] = vprod[a][47:16];
         s1_fdt_in[a] = fprod[a][47:16];
         s1_gdt_in[a] = gprod[a][47:16];
      end
      lprod       = req_if.payload.life_left * $signed({1'b0, inv_life_ff});
      s1_r_in     = lprod[63:16];
      ldiff       = 33'(req_if.payload.life_left) - $signed({17'b0, req_if.payload.time_step});
      s1_nlife_in = sat32(50'(ldiff));
      s1_exp_in   = (s1_nlife_in <= 32'sd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (adv1) begin
         s1_v_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_pos_ff   <= s1_pos_in;
         s1_vel_ff   <= s1_vel_in;
         s1_vdt_ff   <= s1_vdt_in;
         s1_fdt_ff   <= s1_fdt_in;
         s1_gdt_ff   <= s1_gdt_in;
         s1_r_ff     <= s1_r_in;
         s1_nlife_ff <= s1_nlife_in;
         s1_exp_ff   <= s1_exp_in;
      end
   end

   // Stage 2: force times mass, position update, velocity plus gravity sum and life fraction.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         psum[a]     = 33'(s1_pos_ff[a]) + 33'(s1_vdt_ff[a]);
         s2_np_in[a] = sat32(50'(psum[a]));
         s2_vg_in[a] = 33'(s1_vel_ff[a]) + 33'(s1_gdt_ff[a]);
         mprod[a]    = s1_fdt_ff[a] * $signed({1'b0, mass_ff});
         s2_fm_in[a] = mprod[a][63:16];
      end
      if (s1_r_ff <= 48'sd0) begin
         s2_frac_in = FRAC_ONE;
      end else if (s1_r_ff >= 48'sd65536) begin
         s2_frac_in = '0;
      end else begin
         s2_frac_in = FRAC_W'(48'sd65536 - s1_r_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (adv2) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_np_ff    <= s2_np_in;
         s2_vg_ff    <= s2_vg_in;
         s2_fm_ff    <= s2_fm_in;
         s2_frac_ff  <= s2_frac_in;
         s2_nlife_ff <= s1_nlife_ff;
         s2_exp_ff   <= s1_exp_ff;
      end
   end

   // Stage 3: velocity sum and interpolation products. Entry 3 is the size,
   // entries 0 to 2 are the blue, green and red channels.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         s3_nv_in[a] = sat32(50'(s2_vg_ff[a]) + 50'(s2_fm_ff[a]));
         lerp_a[a]   = {8'b0, start_color_ff[a*8 +: 8]};
         lerp_b[a]   = {8'b0, end_color_ff[a*8 +: 8]};
      end
      lerp_a[3] = size_range_ff[31:16];
      lerp_b[3] = size_range_ff[15:0];
      for (int k = 0; k < 4; k++) begin
         lerp_d[k]    = $signed({1'b0, lerp_b[k]}) - $signed({1'b0, lerp_a[k]});
         lerp_p[k]    = lerp_d[k] * $signed({1'b0, s2_frac_ff});
         s3_off_in[k] = lerp_p[k][34:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (adv3) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         s3_nv_ff    <= s3_nv_in;
         s3_off_ff   <= s3_off_in;
         s3_np_ff    <= s2_np_ff;
         s3_nlife_ff <= s2_nlife_ff;
         s3_exp_ff   <= s2_exp_ff;
      end
   end

   // Output stage: interpolation sums and result assembly.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         lerp_sum[k] = {3'b0, lerp_a[k]} + s3_off_ff[k];
      end
      out_in.new_pos_x      = s3_np_ff[0];
      out_in.new_pos_y      = s3_np_ff[1];
      out_in.new_pos_z      = s3_np_ff[2];
      out_in.new_vel_x      = s3_nv_ff[0];
      out_in.new_vel_y      = s3_nv_ff[1];
      out_in.new_vel_z      = s3_nv_ff[2];
      out_in.new_life_left  = s3_nlife_ff;
      out_in.particle_size  = lerp_sum[3][15:0];
      out_in.particle_color = {lerp_sum[2][7:0], lerp_sum[1][7:0], lerp_sum[0][7:0]};
      out_in.expired        = s3_exp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv_out) begin
         out_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_out) begin
         out_ff <= out_in;
      end
   end

`ifndef SYNTHESIS
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> s1_v_ff)
      else $error("accepted item did not enter the first stage");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s2_v_ff && !adv3 |=> s2_v_ff && $stable(s2_frac_ff) && $stable(s2_nlife_ff))
      else $error("stalled second stage lost or changed its item");

   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      s2_v_ff |-> s2_frac_ff <= FRAC_ONE)
      else $error("life fraction above one");

   a_expired_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> rsp_if.payload.expired == (rsp_if.payload.new_life_left <= 32'sd0))
      else $error("expired flag disagrees with remaining life");
`endif

endmodule
